// ----- hdl/bsfe_pkg.sv -----
`default_nettype none

package bsfe_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE = 8'h7D;
   localparam logic [7:0] ESC_FLIP = 8'h20;
   localparam logic [7:0] ALL_ONES = 8'hFF;

   localparam int MAX_BYTES = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_FINISH = 2'd2
   } mode_type;

   // One queue entry holds every output word that a single input word produces.
   typedef struct packed {
      logic [1:0] count;
      logic [MAX_BYTES-1:0][7:0] bytes;
   } frame_entry_type;

endpackage

`default_nettype wire

// ----- hdl/bsfe_front.sv -----
`default_nettype none

module bsfe_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_mode,
   input wire logic [7:0] req_data_byte,
   input wire logic [7:0] req_command_bits,
   input wire logic [7:0] req_device_id,
   input wire logic queue_full,
   output logic push,
   output bsfe_pkg::frame_entry_type push_entry
);
   import bsfe_pkg::*;

   logic [7:0] running_xor_ff;
   logic [7:0] running_xor_in;
   logic [7:0] header;
   logic [7:0] checksum;
   logic data_escaped;
   logic sum_escaped;
   logic keep;
   logic accept;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;
   assign push = accept && keep;

   assign header = req_command_bits | req_device_id;
   assign checksum = running_xor_ff ^ ALL_ONES;
   assign data_escaped = (req_data_byte == FLAG_BYTE) || (req_data_byte == ESC_BYTE);
   assign sum_escaped = (checksum == FLAG_BYTE) || (checksum == ESC_BYTE);

   always_comb begin
      keep = 1'b1;
      running_xor_in = running_xor_ff;
      push_entry.count = 2'd1;
      push_entry.bytes = '0;
      unique case (mode_type'(req_mode))
         MODE_START: begin
            push_entry.count = 2'd2;
            push_entry.bytes[0] = FLAG_BYTE;
            push_entry.bytes[1] = header;
            running_xor_in = header;
         end
         MODE_PAYLOAD: begin
            if (data_escaped) begin
               push_entry.count = 2'd2;
               push_entry.bytes[0] = ESC_BYTE;
               push_entry.bytes[1] = req_data_byte ^ ESC_FLIP;
               running_xor_in = running_xor_ff ^ ESC_BYTE ^ req_data_byte ^ ESC_FLIP;
            end else begin
               push_entry.count = 2'd1;
               push_entry.bytes[0] = req_data_byte;
               running_xor_in = running_xor_ff ^ req_data_byte;
            end
         end
         MODE_FINISH: begin
            if (sum_escaped) begin
               push_entry.count = 2'd3;
               push_entry.bytes[0] = ESC_BYTE;
               push_entry.bytes[1] = checksum ^ ESC_FLIP;
               push_entry.bytes[2] = FLAG_BYTE;
            end else begin
               push_entry.count = 2'd2;
               push_entry.bytes[0] = checksum;
               push_entry.bytes[1] = FLAG_BYTE;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_xor_ff <= '0;
      end else if (accept) begin
         running_xor_ff <= running_xor_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bsfe_queue.sv -----
`default_nettype none

module bsfe_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire bsfe_pkg::frame_entry_type push_entry,
   output logic full,
   input wire logic pop,
   output logic head_valid,
   output bsfe_pkg::frame_entry_type head_entry
);
   import bsfe_pkg::*;

   frame_entry_type slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bsfe_back.sv -----
`default_nettype none

module bsfe_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input wire bsfe_pkg::frame_entry_type head_entry,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last
);
   import bsfe_pkg::*;

   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic run_last_ff;
   logic load;
   logic last_byte;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last_byte = (pos_ff == 2'(head_entry.count - 2'd1));
   assign pop = load && last_byte;

   always_comb begin
      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         pos_in = last_byte ? 2'd0 : pos_ff + 2'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= head_entry.bytes[pos_ff];
         run_last_ff <= last_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;

   // A partly sent entry stays at the head of the queue until its last word leaves.
   a_mid_entry_has_head: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd0 |-> head_valid)
      else $error("entry position advanced with an empty queue");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> pos_ff < head_entry.count)
      else $error("entry position beyond the entry length");

   a_entry_not_empty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> head_entry.count != 2'd0)
      else $error("queued entry carries no words");

   a_last_resets_pos: assert property (@(posedge clock) disable iff (reset)
      pop |=> pos_ff == 2'd0)
      else $error("entry position not cleared after the last word");

endmodule

`default_nettype wire

// ----- hdl/byte_stuffed_frame_encoder.sv -----
`default_nettype none

// Byte-stuffed frame encoder with an inverted XOR checksum. A start word sends the flag 0x7E and
// the header (command OR id), a payload word sends its byte with 0x7E and 0x7D escaped, and a
// finish word sends the escaped checksum and the closing flag; mode three is dropped. The output
// port moves one byte per cycle while rsp_ready is high, so an input word yields one to three
// bytes: a start gives two, a payload one or two, a finish two or three. A two-entry queue sits
// between the classifying front end and the serializer, so new words are taken while earlier
// bytes still wait on the output; bytes go through a queue slot, then the output register.
module byte_stuffed_frame_encoder (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_mode,
   input wire logic [7:0] req_data_byte,
   input wire logic [7:0] req_command_bits,
   input wire logic [7:0] req_device_id,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last
);
   import bsfe_pkg::*;

   logic push;
   logic pop;
   logic queue_full;
   logic head_valid;
   frame_entry_type push_entry;
   frame_entry_type head_entry;

   bsfe_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .req_command_bits(req_command_bits),
      .req_device_id(req_device_id),
      .queue_full(queue_full),
      .push(push),
      .push_entry(push_entry)
   );

   bsfe_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(queue_full),
      .pop(pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   bsfe_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

endmodule

`default_nettype wire

// ----- verif/byte_stuffed_frame_encoder_test.sv -----
`timescale 1ns / 1ps

module byte_stuffed_frame_encoder_test;
   import bsfe_pkg::*;

   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int RANDOM_WORDS = 108;
   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic [7:0] value;
      logic last;
   } wire_byte_type;

   class frame_scoreboard_type;
      logic [7:0] running_sum;
      wire_byte_type pending_bytes[$];
      int errors;

      function new();
         running_sum = 8'h00;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void push_byte(input logic [7:0] value, input logic last);
         wire_byte_type b;
         b.value = value;
         b.last = last;
         pending_bytes.push_back(b);
      endfunction

      // The escaped form of a byte ends the item only when last is set.
      function void push_stuffed(input logic [7:0] value, input logic last);
         if (value == FLAG_BYTE || value == ESC_BYTE) begin
            push_byte(ESC_BYTE, 1'b0);
            push_byte(value ^ ESC_FLIP, last);
         end else begin
            push_byte(value, last);
         end
      endfunction

      function void note_word(input logic [1:0] mode, input logic [7:0] data,
                              input logic [7:0] cmd, input logic [7:0] id);
         logic [7:0] header;
         case (mode)
            MODE_START: begin
               header = cmd | id;
               push_byte(FLAG_BYTE, 1'b0);
               push_byte(header, 1'b1);
               running_sum = header;
            end
            MODE_PAYLOAD: begin
               if (data == FLAG_BYTE || data == ESC_BYTE) begin
                  running_sum = running_sum ^ ESC_BYTE ^ (data ^ ESC_FLIP);
               end else begin
                  running_sum = running_sum ^ data;
               end
               push_stuffed(data, 1'b1);
            end
            MODE_FINISH: begin
               push_stuffed(running_sum ^ ALL_ONES, 1'b0);
               push_byte(FLAG_BYTE, 1'b1);
            end
            default: begin
            end
         endcase
      endfunction

      task check_byte(input logic [7:0] value, input logic last);
         wire_byte_type want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", value, last));
         end else begin
            want = pending_bytes.pop_front();
            if (value !== want.value) begin
               report($sformatf("out_byte %02h, wanted %02h", value, want.value));
            end
            if (last !== want.last) begin
               report($sformatf("run_last %0b on byte %02h, wanted %0b", last, value,
                                want.last));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = MODE_IGNORED;
   logic [7:0] req_data_byte = 8'h00;
   logic [7:0] req_command_bits = 8'h00;
   logic [7:0] req_device_id = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_run_last;

   frame_scoreboard_type sb = new();
   int words_taken = 0;
   int frame_words = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   byte_stuffed_frame_encoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .req_command_bits(req_command_bits),
      .req_device_id(req_device_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_word(req_mode, req_data_byte, req_command_bits, req_device_id);
         words_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte(rsp_out_byte, rsp_run_last);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("byte_stuffed_frame_encoder_test NOT OK");
            $finish;
         end
      end
   end

   // The sender runs in bursts; valid drops only between bursts.
   task send_word(input logic [1:0] mode, input logic [7:0] data, input logic [7:0] cmd,
                  input logic [7:0] id);
      int gap;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data_byte <= data;
      req_command_bits <= cmd;
      req_device_id <= id;
      do begin
         @(posedge clock);
      end while (!req_ready);
      if (mode != MODE_IGNORED) begin
         frame_words++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(0, 8);
      end
   endtask

   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 11))
         0: pick_payload = FLAG_BYTE;
         1: pick_payload = ESC_BYTE;
         2: pick_payload = FLAG_BYTE ^ ESC_FLIP;
         3: pick_payload = ESC_BYTE ^ ESC_FLIP;
         default: pick_payload = 8'($urandom_range(0, 255));
      endcase
   endfunction

   task send_frame(input int payloads, input logic close);
      send_word(MODE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      repeat (payloads) begin
         send_word(MODE_PAYLOAD, pick_payload(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
      if (close) begin
         send_word(MODE_FINISH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int segment_len;
      int segment_kind;
      bit held_off;
      held_off = 0;
      @(negedge reset);
      forever begin
         if (!held_off && words_taken >= 40) begin
            held_off = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         segment_kind = $urandom_range(0, 3);
         segment_len = $urandom_range(5, 40);
         for (int i = 0; i < segment_len; i++) begin
            case (segment_kind)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (i % 3 != 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(MODE_FINISH, 8'hA5, 8'h5A, 8'hC3);
      send_word(MODE_PAYLOAD, 8'h00, 8'hFF, 8'hFF);
      send_word(MODE_IGNORED, 8'h7E, 8'h7D, 8'hFF);
      send_word(MODE_FINISH, 8'hFF, 8'h00, 8'h00);
      send_word(MODE_START, 8'hFF, 8'h00, 8'h00);
      send_word(MODE_PAYLOAD, FLAG_BYTE, 8'h00, 8'hFF);
      send_word(MODE_PAYLOAD, ESC_BYTE, 8'hFF, 8'h00);
      send_word(MODE_PAYLOAD, 8'hFF, 8'h00, 8'h00);
      send_word(MODE_PAYLOAD, FLAG_BYTE ^ ESC_FLIP, 8'h00, 8'h00);
      send_word(MODE_FINISH, 8'h00, 8'hFF, 8'hFF);
      send_word(MODE_FINISH, 8'h7E, 8'h7E, 8'h7E);
      send_word(MODE_START, 8'h00, 8'h7C, 8'h02);
      send_word(MODE_PAYLOAD, 8'h00, 8'h00, 8'h00);
      send_word(MODE_IGNORED, 8'h00, 8'h00, 8'h00);
      send_word(MODE_FINISH, 8'h00, 8'h00, 8'h00);
      send_word(MODE_START, 8'h00, 8'h80, 8'h01);
      send_word(MODE_FINISH, 8'h00, 8'h00, 8'h00);
      send_word(MODE_START, 8'h00, 8'h02, 8'h80);
      send_word(MODE_FINISH, 8'h00, 8'h00, 8'h00);
      send_word(MODE_START, 8'h00, 8'hFF, 8'hFF);
      send_word(MODE_PAYLOAD, ESC_BYTE ^ ESC_FLIP, 8'hFF, 8'hFF);
      send_word(MODE_FINISH, 8'hFF, 8'hFF, 8'hFF);

      frame_words = 0;
      while (frame_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(0, 4), 1'b1);
         end else if (pick == 8) begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 1) == 0) begin
            send_frame($urandom_range(0, 3), 1'b0);
         end else begin
            send_frame($urandom_range(0, 3), 1'b1);
            send_word(MODE_FINISH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("byte_stuffed_frame_encoder_test OK");
      end else begin
         $display("byte_stuffed_frame_encoder_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- byte_stuffed_frame_encoder.f -----
hdl/bsfe_pkg.sv
hdl/bsfe_front.sv
hdl/bsfe_queue.sv
hdl/bsfe_back.sv
hdl/byte_stuffed_frame_encoder.sv
verif/byte_stuffed_frame_encoder_test.sv
